### rtl/core/rrts_pkg.sv
package rrts_pkg;

  // default table size
  localparam int TASK_SLOTS_DEF = 8;

  // stream widths
  localparam int IN_W  = 24;
  localparam int OUT_W = 8;

  // commands
  localparam logic [2:0] CMD_TICK  = 3'd0;
  localparam logic [2:0] CMD_REG   = 3'd1;
  localparam logic [2:0] CMD_START = 3'd2;
  localparam logic [2:0] CMD_YIELD = 3'd3;
  localparam logic [2:0] CMD_DELAY = 3'd4;

  // slot status codes
  localparam logic [1:0] ST_EMPTY   = 2'd0;
  localparam logic [1:0] ST_READY   = 2'd1;
  localparam logic [1:0] ST_RUNNING = 2'd2;
  localparam logic [1:0] ST_DELAYED = 2'd3;

  // per-slot operations
  localparam logic [2:0] OP_NONE  = 3'd0;
  localparam logic [2:0] OP_REG   = 3'd1;
  localparam logic [2:0] OP_RUN   = 3'd2;
  localparam logic [2:0] OP_READY = 3'd3;
  localparam logic [2:0] OP_DELAY = 3'd4;

  // control broadcast to every slot cell
  typedef struct packed {
    logic       tick;
    logic [2:0] op;
    logic       tok_load;
    logic       tok_shift;
  } cell_cmd_t;

endpackage

### rtl/core/round_robin_task_scheduler.sv
// tick, register, start and unknown commands give their result in the cycle after
// the input transfer; yield and delay first enter the scan state, where the search
// token steps slot by slot along the cell chain, and give their result when it stops
// throughput: one command at a time; a new transfer is taken once the scan is over
// and no result is stalled; reset (synchronous, rst high): slot 0 ready, other slots
// empty, counters zero, current task idle, registered count one; no clearing pass
module round_robin_task_scheduler #(
  parameter int TASK_SLOTS = rrts_pkg::TASK_SLOTS_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       s_axis_tvalid,
  output logic                       s_axis_tready,
  // command[2:0], task_id[5:3], delay_ticks[21:6], zero[23:22]
  input  logic [rrts_pkg::IN_W-1:0]  s_axis_tdata,
  output logic                       m_axis_tvalid,
  input  logic                       m_axis_tready,
  // running_slot[2:0], idle_fallback[3], accepted[4], assigned_slot[7:5]
  output logic [rrts_pkg::OUT_W-1:0] m_axis_tdata
);
  import rrts_pkg::*;

  localparam int IW = (TASK_SLOTS > 1) ? $clog2(TASK_SLOTS) : 1;
  localparam int CW = $clog2(TASK_SLOTS + 1);
  localparam int TW = ((IW > 3) ? IW : 3) + 1;
  localparam logic [IW-1:0] LAST_SLOT = IW'(TASK_SLOTS - 1);
  localparam logic [IW-1:0] SCAN_LAST = IW'(TASK_SLOTS - 2);

  localparam logic STATE_IDLE = 1'b0;
  localparam logic STATE_SCAN = 1'b1;

  logic [0:0]    state, state_next;
  logic [IW-1:0] current, current_next;
  logic [CW-1:0] reg_count, reg_count_next;
  logic [IW-1:0] scan_idx, scan_idx_next;
  logic [IW-1:0] scan_n, scan_n_next;

  logic [2:0]    cmd_in;
  logic [2:0]    tid_in;
  logic [15:0]   ticks_in;
  logic          take;
  logic          out_load;
  logic [OUT_W-1:0] res;

  cell_cmd_t     ccmd;
  logic [IW-1:0] op_idx;
  logic [IW-1:0] tok_idx;
  logic [IW-1:0] chosen;
  logic          finish;
  logic          fallback;

  logic [TASK_SLOTS-1:0] tok_vec;
  logic [TASK_SLOTS-1:0] found_vec;

  function automatic logic [IW-1:0] next_slot(input logic [IW-1:0] t);
    if (t < LAST_SLOT) begin
      return t + 1'b1;
    end
    return IW'(1);
  endfunction

  assign cmd_in   = s_axis_tdata[2:0];
  assign tid_in   = s_axis_tdata[5:3];
  assign ticks_in = s_axis_tdata[21:6];

  assign s_axis_tready = (state == STATE_IDLE) && (!m_axis_tvalid || m_axis_tready);
  assign take          = s_axis_tvalid && s_axis_tready;

  // command decode and scan control
  always_comb begin
    state_next     = state;
    current_next   = current;
    reg_count_next = reg_count;
    scan_idx_next  = scan_idx;
    scan_n_next    = scan_n;
    ccmd           = '0;
    ccmd.op        = OP_NONE;
    op_idx         = current;
    tok_idx        = next_slot(current);
    out_load       = 1'b0;
    res            = {3'd0, 1'b1, 1'b0, 3'(current)};
    chosen         = '0;
    finish         = 1'b0;
    fallback       = 1'b0;

    if (state == STATE_IDLE) begin
      if (take) begin
        case (cmd_in)
          CMD_TICK: begin
            ccmd.tick = 1'b1;
            out_load  = 1'b1;
          end
          CMD_REG: begin
            out_load = 1'b1;
            if (reg_count < CW'(TASK_SLOTS)) begin
              ccmd.op        = OP_REG;
              op_idx         = IW'(reg_count);
              reg_count_next = reg_count + 1'b1;
              res            = {3'(reg_count), 1'b1, 1'b0, 3'(current)};
            end else begin
              res = {3'd0, 1'b0, 1'b0, 3'(current)};
            end
          end
          CMD_START: begin
            out_load = 1'b1;
            if (TW'(tid_in) < TW'(TASK_SLOTS)) begin
              ccmd.op      = OP_RUN;
              op_idx       = IW'(tid_in);
              current_next = IW'(tid_in);
              res          = {3'd0, 1'b1, 1'b0, tid_in};
            end
          end
          CMD_YIELD, CMD_DELAY: begin
            ccmd.op       = (cmd_in == CMD_YIELD) ? OP_READY : OP_DELAY;
            ccmd.tok_load = 1'b1;
            state_next    = STATE_SCAN;
            scan_idx_next = next_slot(current);
            scan_n_next   = '0;
          end
          default: begin
            out_load = 1'b1;
          end
        endcase
      end
    end else begin
      // one slot per cycle: stop on the current slot, a ready slot or a full pass
      if (scan_idx == current) begin
        finish   = 1'b1;
        fallback = 1'b1;
      end else if (|found_vec) begin
        finish = 1'b1;
        chosen = scan_idx;
      end else if (scan_n == SCAN_LAST) begin
        finish   = 1'b1;
        fallback = 1'b1;
      end else begin
        ccmd.tok_shift = 1'b1;
        scan_idx_next  = next_slot(scan_idx);
        scan_n_next    = scan_n + 1'b1;
      end
      if (finish) begin
        ccmd.op      = OP_RUN;
        op_idx       = chosen;
        current_next = chosen;
        state_next   = STATE_IDLE;
        out_load     = 1'b1;
        res          = {3'd0, 1'b1, fallback, 3'(chosen)};
      end
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= STATE_IDLE;
      current   <= '0;
      reg_count <= CW'(1);
      scan_idx  <= '0;
      scan_n    <= '0;
    end else begin
      state     <= state_next;
      current   <= current_next;
      reg_count <= reg_count_next;
      scan_idx  <= scan_idx_next;
      scan_n    <= scan_n_next;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (out_load) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      m_axis_tdata <= res;
    end
  end

  // row of slot cells; the token ring runs over slots 1 .. TASK_SLOTS-1
  for (genvar i = 0; i < TASK_SLOTS; i++) begin : g_cell
    logic tok_prev;
    if (i == 0) begin : g_idle
      assign tok_prev = 1'b0;
    end else if (i == 1) begin : g_wrap
      assign tok_prev = tok_vec[TASK_SLOTS-1];
    end else begin : g_link
      assign tok_prev = tok_vec[i-1];
    end

    rrts_cell u_cell (
      .clk        (clk),
      .rst        (rst),
      .cmd        (ccmd),
      .sel        (op_idx == IW'(i)),
      .tok_sel    ((i != 0) && (tok_idx == IW'(i))),
      .rst_status ((i == 0) ? ST_READY : ST_EMPTY),
      .ticks      (ticks_in),
      .lid_in     (tid_in),
      .tok_in     (tok_prev),
      .tok        (tok_vec[i]),
      .found      (found_vec[i])
    );
  end

endmodule

### rtl/core/rrts_cell.sv
module rrts_cell (
  input  logic                clk,
  input  logic                rst,
  input  rrts_pkg::cell_cmd_t cmd,
  input  logic                sel,
  input  logic                tok_sel,
  input  logic [1:0]          rst_status,
  input  logic [15:0]         ticks,
  input  logic [2:0]          lid_in,
  input  logic                tok_in,
  output logic                tok,
  output logic                found
);
  import rrts_pkg::*;

  logic [1:0]  status, status_next;
  logic [15:0] cnt, cnt_next, cnt_dec;
  logic [2:0]  lid, lid_next;
  logic        tok_next;

  assign cnt_dec = cnt - 16'd1;

  // tick countdown and slot operations
  always_comb begin
    status_next = status;
    cnt_next    = cnt;
    lid_next    = lid;
    if (cmd.tick && status == ST_DELAYED) begin
      cnt_next = cnt_dec;
      if (cnt_dec == 16'd0) begin
        status_next = ST_READY;
      end
    end
    if (sel) begin
      case (cmd.op)
        OP_REG: begin
          status_next = ST_READY;
          cnt_next    = 16'd0;
          lid_next    = lid_in;
        end
        OP_RUN: begin
          status_next = ST_RUNNING;
        end
        OP_READY: begin
          status_next = ST_READY;
        end
        OP_DELAY: begin
          status_next = ST_DELAYED;
          cnt_next    = ticks;
        end
        default: begin
        end
      endcase
    end
  end

  // search token, handed to the next cell on each scan step
  always_comb begin
    if (cmd.tok_load) begin
      tok_next = tok_sel;
    end else if (cmd.tok_shift) begin
      tok_next = tok_in;
    end else begin
      tok_next = tok;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      status <= rst_status;
      cnt    <= 16'd0;
      lid    <= 3'd0;
      tok    <= 1'b0;
    end else begin
      status <= status_next;
      cnt    <= cnt_next;
      lid    <= lid_next;
      tok    <= tok_next;
    end
  end

  assign found = tok && (status == ST_READY);

endmodule

### rtl/core/rrts_checker.sv
module rrts_checker (
  input logic       clk,
  input logic       rst,
  input logic       s_axis_tready,
  input logic       m_axis_tvalid,
  input logic       m_axis_tready,
  input logic [7:0] m_axis_tdata
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tready) |=> $stable(m_axis_tdata))
    else $error("result changed while stalled");

  // falling back always lands on the idle slot
  a_fallback_idle: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tdata[3]) |-> (m_axis_tdata[2:0] == 3'd0))
    else $error("idle fallback with a non-idle current task");

  // a refused register reports no slot
  a_refused_slot: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tdata[4]) |-> (m_axis_tdata[7:5] == 3'd0))
    else $error("slot reported for a refused register");

  // no new command while a result is stalled
  a_no_take_stalled: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tready) |-> !s_axis_tready)
    else $error("input ready while result is stalled");

endmodule

bind round_robin_task_scheduler rrts_checker u_rrts_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

### test/tb_round_robin_task_scheduler.sv
`timescale 1ns / 1ps

module tb_round_robin_task_scheduler;
  import rrts_pkg::*;

  localparam int NSLOTS = TASK_SLOTS_DEF;
  localparam int ZERO_DELAY_TICKS = 8;
  localparam int RANDOM_CMDS = 1120;
  localparam int CHUNK = 100;

  // command codes the block decodes as no-ops
  localparam logic [2:0] CMD_RSVD_FIRST = CMD_DELAY + 3'd1;
  localparam logic [2:0] CMD_RSVD_LAST  = 3'd7;

  // one result transfer, laid out as on m_axis_tdata
  typedef struct packed {
    logic [2:0] slot;
    logic       accepted;
    logic       fallback;
    logic [2:0] current;
  } sched_result_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              s_axis_tvalid = 1'b0;
  logic              s_axis_tready;
  logic [IN_W-1:0]   s_axis_tdata = '0;
  logic              m_axis_tvalid;
  logic              m_axis_tready = 1'b0;
  logic [OUT_W-1:0]  m_axis_tdata;

  // scheduler state as the testbench tracks it
  logic [1:0]  slot_state [NSLOTS];
  logic [15:0] slot_wait  [NSLOTS];
  logic [2:0]  slot_lid   [NSLOTS];
  int          cur_slot;
  int          reg_count;

  sched_result_t sched_expected_q[$];
  sched_result_t want_res;
  sched_result_t got_res;
  int            mismatch_count = 0;
  bit            no_idle = 1'b0;
  int            next_gap = 0;
  int            stall_left = 0;
  int            pause;

  round_robin_task_scheduler #(
    .TASK_SLOTS(NSLOTS)
  ) u_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always #4 clk = ~clk;

  // state right after reset
  function automatic void sched_reset();
    for (int i = 0; i < NSLOTS; i++) begin
      slot_state[i] = ST_EMPTY;
      slot_wait[i]  = '0;
      slot_lid[i]   = '0;
    end
    slot_state[0] = ST_READY;
    cur_slot = 0;
    reg_count = 1;
  endfunction

  // round robin search over slots 1..NSLOTS-1, idle when nothing is ready
  function automatic logic pick_next_ready();
    int from;
    int t;
    int chosen;
    logic fell_back;
    from = cur_slot;
    t = from;
    chosen = 0;
    fell_back = 1'b1;
    for (int n = 0; n + 1 < NSLOTS; n++) begin
      t = (t < NSLOTS - 1) ? t + 1 : 1;
      if (t == from) break;
      if (slot_state[t] == ST_READY) begin
        chosen = t;
        fell_back = 1'b0;
        break;
      end
    end
    cur_slot = chosen;
    slot_state[chosen] = ST_RUNNING;
    return fell_back;
  endfunction

  // apply one command and return the result the block should give
  function automatic sched_result_t sched_step(input logic [2:0] cmd, input logic [2:0] tid,
                                               input logic [15:0] ticks);
    sched_result_t r;
    r = '0;
    r.accepted = 1'b1;
    case (cmd)
      CMD_TICK: begin
        for (int i = 0; i < NSLOTS; i++) begin
          if (slot_state[i] == ST_DELAYED) begin
            slot_wait[i] = slot_wait[i] - 16'd1;
            if (slot_wait[i] == 16'd0) slot_state[i] = ST_READY;
          end
        end
      end
      CMD_REG: begin
        if (reg_count < NSLOTS) begin
          r.slot = reg_count[2:0];
          slot_state[reg_count] = ST_READY;
          slot_wait[reg_count] = '0;
          slot_lid[reg_count] = tid;
          reg_count++;
        end else begin
          r.accepted = 1'b0;
        end
      end
      CMD_START: begin
        if (tid < NSLOTS) begin
          slot_state[tid] = ST_RUNNING;
          cur_slot = int'(tid);
        end
      end
      CMD_YIELD: begin
        slot_state[cur_slot] = ST_READY;
        r.fallback = pick_next_ready();
      end
      CMD_DELAY: begin
        slot_wait[cur_slot] = ticks;
        slot_state[cur_slot] = ST_DELAYED;
        r.fallback = pick_next_ready();
      end
      default: ;
    endcase
    r.current = cur_slot[2:0];
    return r;
  endfunction

  task automatic report_mismatch(input string msg);
    mismatch_count++;
    $display("%0t mismatch: %s", $realtime, msg);
  endtask

  task automatic check_field(input string name, input logic [2:0] got, input logic [2:0] want);
    if (got !== want) report_mismatch($sformatf("%s got %0d want %0d", name, got, want));
  endtask

  // result side: compare each transfer, then draw a stall before the next one
  always @(posedge clk) begin
    if (!rst && m_axis_tvalid === 1'b1 && m_axis_tready) begin
      if (sched_expected_q.size() == 0) begin
        report_mismatch("result transfer with no command pending");
      end else begin
        want_res = sched_expected_q.pop_front();
        got_res = m_axis_tdata;
        check_field("running_slot", got_res.current, want_res.current);
        check_field("idle_fallback", 3'(got_res.fallback), 3'(want_res.fallback));
        check_field("accepted", 3'(got_res.accepted), 3'(want_res.accepted));
        check_field("assigned_slot", got_res.slot, want_res.slot);
      end
      pause = no_idle ? 0 : $urandom_range(0, 7);
      stall_left <= pause;
      m_axis_tready <= (pause == 0);
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      m_axis_tready <= (stall_left == 1);
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  // one command transfer; valid stays up when the next command follows at once
  task automatic send_cmd(input logic [2:0] cmd, input logic [2:0] tid,
                          input logic [15:0] ticks);
    if (next_gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (next_gap) @(posedge clk);
    end
    s_axis_tdata <= {2'b00, ticks, tid, cmd};
    s_axis_tvalid <= 1'b1;
    do @(posedge clk); while (s_axis_tready !== 1'b1);
    sched_expected_q.push_back(sched_step(cmd, tid, ticks));
    next_gap = no_idle ? 0 : $urandom_range(0, 7);
  endtask

  // hold off new commands until every result is back
  task automatic wait_all_results();
    s_axis_tvalid <= 1'b0;
    next_gap = 0;
    while (sched_expected_q.size() != 0) @(posedge clk);
    repeat (NSLOTS + 4) @(posedge clk);
  endtask

  // yield and tick from reset, and every no-op code
  task automatic test_reset_state();
    send_cmd(CMD_YIELD, 3'd0, 16'd0);
    send_cmd(CMD_TICK, 3'd7, 16'hFFFF);
    for (int c = CMD_RSVD_FIRST; c <= CMD_RSVD_LAST; c++) begin
      send_cmd(c[2:0], 3'($urandom), 16'($urandom));
    end
  endtask

  // start of an empty slot, then a zero delay that wraps on the first tick
  task automatic test_zero_delay_wrap();
    send_cmd(CMD_START, 3'd5, 16'd0);
    send_cmd(CMD_DELAY, 3'd0, 16'd0);
    no_idle = 1'b1;
    repeat (ZERO_DELAY_TICKS) send_cmd(CMD_TICK, 3'($urandom), 16'($urandom));
    // counter wrapped to the top: the slot stays delayed
    send_cmd(CMD_YIELD, 3'd0, 16'd0);
    no_idle = 1'b0;
    send_cmd(CMD_YIELD, 3'd0, 16'd0);
    wait_all_results();
  endtask

  // fill the table, then one register too many
  task automatic test_registration();
    send_cmd(CMD_REG, 3'd0, 16'h0000);
    send_cmd(CMD_REG, 3'd7, 16'hFFFF);
    for (int i = 3; i < NSLOTS; i++) send_cmd(CMD_REG, i[2:0], 16'($urandom));
    send_cmd(CMD_REG, 3'd2, 16'd0);
    wait_all_results();
  endtask

  // rotation, delays at both extremes, restart from idle
  task automatic test_scheduling();
    send_cmd(CMD_YIELD, 3'd0, 16'd0);
    send_cmd(CMD_DELAY, 3'd0, 16'hFFFF);
    send_cmd(CMD_DELAY, 3'd0, 16'd1);
    send_cmd(CMD_TICK, 3'd0, 16'd0);
    send_cmd(CMD_START, 3'd0, 16'd0);
    send_cmd(CMD_YIELD, 3'd0, 16'd0);
    send_cmd(CMD_DELAY, 3'd0, 16'h5555);
    send_cmd(CMD_DELAY, 3'd0, 16'hAAAA);
    send_cmd(CMD_YIELD, 3'd0, 16'd0);
    wait_all_results();
  endtask

  // mostly short delays so tasks keep coming back; a few long or zero ones
  function automatic logic [15:0] draw_delay();
    int r;
    r = $urandom_range(0, 99);
    if (r < 80) return 16'($urandom_range(1, 6));
    if (r < 95) return 16'($urandom_range(7, 40));
    if (r < 99) return 16'($urandom);
    return 16'd0;
  endfunction

  task automatic test_random_mix();
    int r;
    logic [2:0] cmd;
    for (int n = 0; n < RANDOM_CMDS; n++) begin
      if (n % CHUNK == 0) no_idle = ($urandom_range(0, 3) == 0);
      if (n == RANDOM_CMDS / 2) wait_all_results();
      r = $urandom_range(0, 99);
      if (r < 35)      cmd = CMD_TICK;
      else if (r < 55) cmd = CMD_YIELD;
      else if (r < 78) cmd = CMD_DELAY;
      else if (r < 88) cmd = CMD_START;
      else if (r < 95) cmd = CMD_REG;
      else             cmd = 3'($urandom_range(CMD_RSVD_FIRST, CMD_RSVD_LAST));
      send_cmd(cmd, 3'($urandom), (cmd == CMD_DELAY) ? draw_delay() : 16'($urandom));
    end
    no_idle = 1'b0;
  endtask

  initial begin
    sched_reset();
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_reset_state();
    test_zero_delay_wrap();
    test_registration();
    test_scheduling();
    test_random_mix();
    wait_all_results();
    if (mismatch_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // run limit
  initial begin
    #20_000_000;
    $display("TEST FAILED");
    $finish;
  end

endmodule

### files.f
rtl/core/rrts_pkg.sv
rtl/core/rrts_cell.sv
rtl/core/round_robin_task_scheduler.sv
rtl/core/rrts_checker.sv
test/tb_round_robin_task_scheduler.sv
